// ----- sv/bmi_pkg.sv -----
// ----------------------------------------------------------------------------
// bmi_pkg
// Shared constants, register indexes and fixed-point helpers for the body
// motion integrator.
// ----------------------------------------------------------------------------
package bmi_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int FR_SHIFT      = 16;
    localparam int ADDR_W        = 5;

    localparam logic [16:0] FR_ONE      = 17'd65536;
    localparam logic [16:0] FLOOR_KEEP  = 17'd64881;
    localparam logic [16:0] WALL_KEEP   = 17'd52429;
    localparam logic [16:0] GROUND_KEEP = 17'd34953;

    localparam logic signed [47:0] S32_MAX = 48'sd2147483647;
    localparam logic signed [47:0] S32_MIN = -48'sd2147483648;

    typedef enum logic [2:0] {
        CFG_GRAVITY_ACCEL = 3'd0,
        CFG_GRAVITY_ON    = 3'd1,
        CFG_TIME_STEP     = 3'd2,
        CFG_AREA_WIDTH    = 3'd3,
        CFG_AREA_HEIGHT   = 3'd4
    } cfg_idx_t;

    typedef logic signed [50:0] prod_t;

    function automatic prod_t fr_mul(input logic signed [32:0] a, input logic [16:0] f);
        return 51'(a) * $signed({34'd0, f});
    endfunction

    function automatic logic signed [34:0] fr_rnd(input prod_t p);
        prod_t t;
        t = (p + 51'sd32768) >>> FR_SHIFT;
        return t[34:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < S32_MIN)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] fr_rs(input prod_t p);
        return sat32(48'(fr_rnd(p)));
    endfunction

endpackage

// ----- sv/bmi_if.sv -----
// ----------------------------------------------------------------------------
// bmi_in_if / bmi_out_if
// Valid/ready channels carrying one body item and one result item.
// ----------------------------------------------------------------------------
interface bmi_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        body_mass;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic [16:0]        drag_fraction;
    logic [11:0]        box_width;
    logic [11:0]        box_height;

    modport source (output valid, pos_x, pos_y, vel_x, vel_y, body_mass, force_x,
                    force_y, drag_fraction, box_width, box_height, input ready);
    modport sink (input valid, pos_x, pos_y, vel_x, vel_y, body_mass, force_x,
                  force_y, drag_fraction, box_width, box_height, output ready);
endinterface

interface bmi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               mass_fault;

    modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                    mass_fault, input ready);
    modport sink (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                  mass_fault, output ready);
endinterface

// ----- sv/bmi_div.sv -----
// ----------------------------------------------------------------------------
// bmi_div
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// ----------------------------------------------------------------------------
module bmi_div #(
    parameter int DW = 48
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] dvd,
    input  logic [30:0]   dvs,
    output logic [DW-1:0] quo
);

    logic [31:0]   rem_reg [DW];
    logic [DW-1:0] num_reg [DW];
    logic [30:0]   dvs_reg [DW];

    genvar k;
    generate
        for (k = 0; k < DW; k++)
        begin : g_stage
            logic [31:0]   r_in;
            logic [DW-1:0] n_in;
            logic [30:0]   d_in;
            logic [31:0]   t;
            logic          ge;

            if (k == 0)
            begin : g_first
                assign r_in = 32'd0;
                assign n_in = dvd;
                assign d_in = dvs;
            end
            else
            begin : g_next
                assign r_in = rem_reg[k-1];
                assign n_in = num_reg[k-1];
                assign d_in = dvs_reg[k-1];
            end

            assign t  = {r_in[30:0], n_in[DW-1]};
            assign ge = t >= {1'b0, d_in};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? (t - {1'b0, d_in}) : t;
                    num_reg[k] <= {n_in[DW-2:0], ge};
                    dvs_reg[k] <= d_in;
                end
            end
        end
    endgenerate

    assign quo = num_reg[DW-1];

endmodule

// ----- sv/body_motion_integrator.sv -----
// ----------------------------------------------------------------------------
// body_motion_integrator
// One explicit Euler step with wall bounce per body, fully pipelined.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// in_item   sink       position, velocity, mass, force, drag, box size
// out_item  source     new position, new velocity, mass fault
// APB       slave      gravity, time step, area size registers
//
// One item enters per cycle while the pipeline advances; the path runs through the input
// register, the two force dividers that resolve one quotient bit per stage, and the post-division stages.
// The whole pipeline advances together; it holds while a result waits unread.
// Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module body_motion_integrator #(
    parameter int FRAC_BITS = bmi_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    bmi_in_if.sink                    in_item,
    bmi_out_if.source                 out_item,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [bmi_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int DW  = 32 + FRAC_BITS;
    localparam int NP  = 13;
    localparam int NST = 1 + DW + NP;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [30:0]        m;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic [16:0]        drag;
        logic [11:0]        bw;
        logic [11:0]        bh;
    } in_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [11:0]        bw;
        logic [11:0]        bh;
        logic [16:0]        keep;
        logic               fault;
        logic               mzero;
        logic               nx;
        logic               ny;
    } dly_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        bmi_pkg::prod_t     px;
        bmi_pkg::prod_t     py;
        logic               flag;
        logic [11:0]        bw;
        logic [11:0]        bh;
        logic [16:0]        keep;
        logic               fault;
    } post_t;

    logic signed [31:0] g_reg;
    logic               gon_reg;
    logic [16:0]        dt_reg;
    logic [11:0]        aw_reg;
    logic [11:0]        ah_reg;
    bmi_pkg::prod_t     gp_reg;

    logic               wr;
    logic               adv;
    logic               acc;
    logic [NST-1:0]     valid_reg;
    logic [NST-1:0]     valid_next;

    in_t                s0_reg;
    dly_t               dl_reg [DW];
    dly_t               dl_next;
    post_t              st_reg [NP];
    post_t              st_next [NP];

    logic [31:0]        absx;
    logic [31:0]        absy;
    logic [DW-1:0]      qx;
    logic [DW-1:0]      qy;
    logic signed [47:0] aw_q;
    logic signed [47:0] ah_q;

    // Configuration port.
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_reg   <= '0;
            gon_reg <= 1'b1;
            dt_reg  <= 17'd1092;
            aw_reg  <= 12'd640;
            ah_reg  <= 12'd480;
        end
        else if (wr)
        begin
            unique case (paddr[bmi_pkg::ADDR_W-1:2])
                bmi_pkg::CFG_GRAVITY_ACCEL: g_reg   <= pwdata;
                bmi_pkg::CFG_GRAVITY_ON:    gon_reg <= pwdata[0];
                bmi_pkg::CFG_TIME_STEP:     dt_reg  <= pwdata[16:0];
                bmi_pkg::CFG_AREA_WIDTH:    aw_reg  <= pwdata[11:0];
                bmi_pkg::CFG_AREA_HEIGHT:   ah_reg  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[bmi_pkg::ADDR_W-1:2])
            bmi_pkg::CFG_GRAVITY_ACCEL: prdata = g_reg;
            bmi_pkg::CFG_GRAVITY_ON:    prdata = {31'd0, gon_reg};
            bmi_pkg::CFG_TIME_STEP:     prdata = {15'd0, dt_reg};
            bmi_pkg::CFG_AREA_WIDTH:    prdata = {20'd0, aw_reg};
            bmi_pkg::CFG_AREA_HEIGHT:   prdata = {20'd0, ah_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        gp_reg <= bmi_pkg::fr_mul(33'(g_reg), dt_reg);
    end

    assign aw_q = $signed(48'(aw_reg) << FRAC_BITS);
    assign ah_q = $signed(48'(ah_reg) << FRAC_BITS);

    // Pipeline control.
    assign adv           = !valid_reg[NST-1] || out_item.ready;
    assign in_item.ready = adv;
    assign acc           = in_item.valid && adv;
    assign valid_next    = {valid_reg[NST-2:0], acc};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg <= '{x: in_item.pos_x, y: in_item.pos_y, vx: in_item.vel_x,
                        vy: in_item.vel_y, m: in_item.body_mass,
                        fx: in_item.force_x, fy: in_item.force_y,
                        drag: in_item.drag_fraction, bw: in_item.box_width,
                        bh: in_item.box_height};
        end
    end

    // Gravity, drag factor and divider operands.
    assign absx = s0_reg.fx[31] ? (32'd0 - s0_reg.fx) : s0_reg.fx;
    assign absy = s0_reg.fy[31] ? (32'd0 - s0_reg.fy) : s0_reg.fy;

    always_comb
    begin
        dl_next.x     = s0_reg.x;
        dl_next.y     = s0_reg.y;
        dl_next.vx    = s0_reg.vx;
        dl_next.vy    = gon_reg
                      ? bmi_pkg::sat32(48'(s0_reg.vy) + 48'(bmi_pkg::fr_rnd(gp_reg)))
                      : s0_reg.vy;
        dl_next.bw    = s0_reg.bw;
        dl_next.bh    = s0_reg.bh;
        dl_next.keep  = bmi_pkg::FR_ONE - ((s0_reg.drag > bmi_pkg::FR_ONE)
                      ? bmi_pkg::FR_ONE : s0_reg.drag);
        dl_next.mzero = s0_reg.m == 31'd0;
        dl_next.fault = (s0_reg.m == 31'd0) && ((s0_reg.fx != 0) || (s0_reg.fy != 0));
        dl_next.nx    = s0_reg.fx[31];
        dl_next.ny    = s0_reg.fy[31];
    end

    bmi_div #(.DW(DW)) u_div_x (
        .clk (clk),
        .en  (adv),
        .dvd ({absx, {FRAC_BITS{1'b0}}}),
        .dvs (s0_reg.m),
        .quo (qx)
    );

    bmi_div #(.DW(DW)) u_div_y (
        .clk (clk),
        .en  (adv),
        .dvd ({absy, {FRAC_BITS{1'b0}}}),
        .dvs (s0_reg.m),
        .quo (qy)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dl_reg[0] <= dl_next;
            for (int k = 1; k < DW; k++)
            begin
                dl_reg[k] <= dl_reg[k-1];
            end
        end
    end

    function automatic logic signed [31:0] acc_sat(input logic [DW-1:0] q,
                                                   input logic neg, input logic mz);
        logic signed [31:0] r;
        if (mz)
        begin
            r = '0;
        end
        else if (neg)
        begin
            r = (q > DW'(33'h080000000)) ? 32'sh80000000 : (32'd0 - q[31:0]);
        end
        else
        begin
            r = (q > DW'(33'h07fffffff)) ? 32'sh7fffffff : q[31:0];
        end
        return r;
    endfunction

    // Post-division stages.
    always_comb
    begin
        dly_t d;
        d = dl_reg[DW-1];

        st_next[0].x     = d.x;
        st_next[0].y     = d.y;
        st_next[0].vx    = d.vx;
        st_next[0].vy    = d.vy;
        st_next[0].px    = 51'(acc_sat(qx, d.nx, d.mzero));
        st_next[0].py    = 51'(acc_sat(qy, d.ny, d.mzero));
        st_next[0].flag  = 1'b0;
        st_next[0].bw    = d.bw;
        st_next[0].bh    = d.bh;
        st_next[0].keep  = d.keep;
        st_next[0].fault = d.fault;

        for (int k = 1; k < NP; k++)
        begin
            st_next[k] = st_reg[k-1];
        end

        st_next[1].px = bmi_pkg::fr_mul(33'($signed(st_reg[0].px[31:0])), dt_reg);
        st_next[1].py = bmi_pkg::fr_mul(33'($signed(st_reg[0].py[31:0])), dt_reg);

        st_next[2].vx = bmi_pkg::sat32(48'(st_reg[1].vx) + 48'(bmi_pkg::fr_rnd(st_reg[1].px)));
        st_next[2].vy = bmi_pkg::sat32(48'(st_reg[1].vy) + 48'(bmi_pkg::fr_rnd(st_reg[1].py)));

        st_next[3].px = bmi_pkg::fr_mul(33'(st_reg[2].vx), st_reg[2].keep);
        st_next[3].py = bmi_pkg::fr_mul(33'(st_reg[2].vy), st_reg[2].keep);

        st_next[4].vx = bmi_pkg::fr_rs(st_reg[3].px);
        st_next[4].vy = bmi_pkg::fr_rs(st_reg[3].py);

        st_next[5].px = bmi_pkg::fr_mul(33'(st_reg[4].vx), dt_reg);
        st_next[5].py = bmi_pkg::fr_mul(33'(st_reg[4].vy), dt_reg);

        st_next[6].x    = bmi_pkg::sat32(48'(st_reg[5].x) + 48'(bmi_pkg::fr_rnd(st_reg[5].px)));
        st_next[6].y    = bmi_pkg::sat32(48'(st_reg[5].y) + 48'(bmi_pkg::fr_rnd(st_reg[5].py)));
        st_next[6].flag = (48'(st_next[6].y) + $signed(48'(st_reg[5].bh) << FRAC_BITS))
                        > ah_q;

        st_next[7].px = bmi_pkg::fr_mul(33'(st_reg[6].vx), bmi_pkg::FLOOR_KEEP);

        if (st_reg[7].flag)
        begin
            st_next[8].vx = bmi_pkg::fr_rs(st_reg[7].px);
        end

        st_next[9].px = bmi_pkg::fr_mul(-(33'(st_reg[8].vx)), bmi_pkg::WALL_KEEP);
        st_next[9].py = bmi_pkg::fr_mul(-(33'(st_reg[8].vy)), bmi_pkg::WALL_KEEP);

        if (st_reg[9].x < 0)
        begin
            st_next[10].x  = '0;
            st_next[10].vx = bmi_pkg::fr_rs(st_reg[9].px);
        end
        if (st_reg[9].y < 0)
        begin
            st_next[10].y  = '0;
            st_next[10].vy = bmi_pkg::fr_rs(st_reg[9].py);
        end

        st_next[11].px = bmi_pkg::fr_mul(-(33'(st_reg[10].vx)), bmi_pkg::WALL_KEEP);
        st_next[11].py = bmi_pkg::fr_mul(-(33'(st_reg[10].vy)), bmi_pkg::GROUND_KEEP);

        if ((48'(st_reg[11].x) + $signed(48'(st_reg[11].bw) << FRAC_BITS)) > aw_q)
        begin
            st_next[12].x  = bmi_pkg::sat32(aw_q - $signed(48'(st_reg[11].bw) << FRAC_BITS));
            st_next[12].vx = bmi_pkg::fr_rs(st_reg[11].px);
        end
        if ((48'(st_reg[11].y) + $signed(48'(st_reg[11].bh) << FRAC_BITS)) > ah_q)
        begin
            st_next[12].y  = bmi_pkg::sat32(ah_q - $signed(48'(st_reg[11].bh) << FRAC_BITS));
            st_next[12].vy = bmi_pkg::fr_rs(st_reg[11].py);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NP; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_item.valid      = valid_reg[NST-1];
    assign out_item.new_pos_x  = st_reg[NP-1].x;
    assign out_item.new_pos_y  = st_reg[NP-1].y;
    assign out_item.new_vel_x  = st_reg[NP-1].vx;
    assign out_item.new_vel_y  = st_reg[NP-1].vy;
    assign out_item.mass_fault = st_reg[NP-1].fault;

endmodule

// ----- verif/body_motion_integrator_tb.sv -----
// ----------------------------------------------------------------------------
// body_motion_integrator_tb
// Streams bodies through the integrator under several register settings and
// compares every result with an in-bench prediction of the Euler step.
// ----------------------------------------------------------------------------
module body_motion_integrator_tb;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [30:0]        body_mass;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic [16:0]        drag_fraction;
        logic [11:0]        box_width;
        logic [11:0]        box_height;
    } body_t;

    typedef struct {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic               mass_fault;
    } motion_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [bmi_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    int error_count = 0;
    int sender_idle = 0;
    int receiver_idle = 0;
    int hold_cycles = 0;
    int bodies_sent = 0;
    int faults_seen = 0;

    logic signed [31:0] cur_gravity;
    logic               cur_gravity_on;
    logic [16:0]        cur_time_step;
    logic [11:0]        cur_area_width;
    logic [11:0]        cur_area_height;

    bmi_in_if  in_item();
    bmi_out_if out_item();

    body_motion_integrator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item.sink),
        .out_item (out_item.source),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic longint sat_s32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint scale_q16(input longint a, input longint f);
        return (a * f + 64'sd32768) >>> 16;
    endfunction

    function automatic motion_t step_body(input body_t b);
        motion_t r;
        longint x, y, vx, vy, m, fx, fy, dt, aw, ah, bw, bh, keep, drag;
        x = longint'(b.pos_x);
        y = longint'(b.pos_y);
        vx = longint'(b.vel_x);
        vy = longint'(b.vel_y);
        m = longint'(b.body_mass);
        fx = longint'(b.force_x);
        fy = longint'(b.force_y);
        dt = longint'(cur_time_step);
        aw = longint'(cur_area_width) <<< 16;
        ah = longint'(cur_area_height) <<< 16;
        bw = longint'(b.box_width) <<< 16;
        bh = longint'(b.box_height) <<< 16;
        drag = longint'(b.drag_fraction);
        r.mass_fault = 1'b0;
        if (cur_gravity_on)
        begin
            vy = sat_s32(vy + scale_q16(longint'(cur_gravity), dt));
        end
        if (m == 0)
        begin
            r.mass_fault = (fx != 0 || fy != 0);
        end
        else
        begin
            vx = sat_s32(vx + scale_q16(sat_s32((fx <<< 16) / m), dt));
            vy = sat_s32(vy + scale_q16(sat_s32((fy <<< 16) / m), dt));
        end
        if (drag > 65536)
        begin
            drag = 65536;
        end
        keep = 65536 - drag;
        vx = sat_s32(scale_q16(vx, keep));
        vy = sat_s32(scale_q16(vy, keep));
        x = sat_s32(x + scale_q16(vx, dt));
        y = sat_s32(y + scale_q16(vy, dt));
        if (y + bh > ah)
        begin
            vx = sat_s32(scale_q16(vx, longint'(bmi_pkg::FLOOR_KEEP)));
        end
        if (x < 0)
        begin
            x = 0;
            vx = sat_s32(scale_q16(-vx, longint'(bmi_pkg::WALL_KEEP)));
        end
        if (x + bw > aw)
        begin
            x = sat_s32(aw - bw);
            vx = sat_s32(scale_q16(-vx, longint'(bmi_pkg::WALL_KEEP)));
        end
        if (y < 0)
        begin
            y = 0;
            vy = sat_s32(scale_q16(-vy, longint'(bmi_pkg::WALL_KEEP)));
        end
        if (y + bh > ah)
        begin
            y = sat_s32(ah - bh);
            vy = sat_s32(scale_q16(-vy, longint'(bmi_pkg::GROUND_KEEP)));
        end
        r.new_pos_x = x[31:0];
        r.new_pos_y = y[31:0];
        r.new_vel_x = vx[31:0];
        r.new_vel_y = vy[31:0];
        return r;
    endfunction

    class motion_scoreboard;
        motion_t pending[$];

        function void note_body(body_t b);
            pending.push_back(step_body(b));
        endfunction

        task check_result(motion_t got);
            motion_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.new_pos_x !== want.new_pos_x)
            begin
                report_mismatch("new_pos_x", got.new_pos_x, want.new_pos_x);
            end
            if (got.new_pos_y !== want.new_pos_y)
            begin
                report_mismatch("new_pos_y", got.new_pos_y, want.new_pos_y);
            end
            if (got.new_vel_x !== want.new_vel_x)
            begin
                report_mismatch("new_vel_x", got.new_vel_x, want.new_vel_x);
            end
            if (got.new_vel_y !== want.new_vel_y)
            begin
                report_mismatch("new_vel_y", got.new_vel_y, want.new_vel_y);
            end
            if (got.mass_fault !== want.mass_fault)
            begin
                report_mismatch("mass_fault", got.mass_fault, want.mass_fault);
            end
        endtask
    endclass

    motion_scoreboard results_sb = new();

    initial
    begin
        in_item.valid = 1'b0;
        in_item.pos_x = '0;
        in_item.pos_y = '0;
        in_item.vel_x = '0;
        in_item.vel_y = '0;
        in_item.body_mass = '0;
        in_item.force_x = '0;
        in_item.force_y = '0;
        in_item.drag_fraction = '0;
        in_item.box_width = '0;
        in_item.box_height = '0;
        out_item.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        motion_t got;
        if (rst_n && in_item.valid && in_item.ready)
        begin
            body_t b;
            b.pos_x = in_item.pos_x;
            b.pos_y = in_item.pos_y;
            b.vel_x = in_item.vel_x;
            b.vel_y = in_item.vel_y;
            b.body_mass = in_item.body_mass;
            b.force_x = in_item.force_x;
            b.force_y = in_item.force_y;
            b.drag_fraction = in_item.drag_fraction;
            b.box_width = in_item.box_width;
            b.box_height = in_item.box_height;
            results_sb.note_body(b);
        end
        if (rst_n && out_item.valid && out_item.ready)
        begin
            got.new_pos_x = out_item.new_pos_x;
            got.new_pos_y = out_item.new_pos_y;
            got.new_vel_x = out_item.new_vel_x;
            got.new_vel_y = out_item.new_vel_y;
            got.mass_fault = out_item.mass_fault;
            if (got.mass_fault)
            begin
                faults_seen++;
            end
            results_sb.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_item.ready <= 1'b0;
        end
        else
        begin
            out_item.ready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    task automatic write_reg(input bmi_pkg::cfg_idx_t idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= bmi_pkg::ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            bmi_pkg::CFG_GRAVITY_ACCEL: cur_gravity = value;
            bmi_pkg::CFG_GRAVITY_ON:    cur_gravity_on = value[0];
            bmi_pkg::CFG_TIME_STEP:     cur_time_step = value[16:0];
            bmi_pkg::CFG_AREA_WIDTH:    cur_area_width = value[11:0];
            bmi_pkg::CFG_AREA_HEIGHT:   cur_area_height = value[11:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] g, input logic on, input logic [16:0] dt,
                              input logic [11:0] aw, input logic [11:0] ah);
        write_reg(bmi_pkg::CFG_GRAVITY_ACCEL, g);
        write_reg(bmi_pkg::CFG_GRAVITY_ON, 32'(on));
        write_reg(bmi_pkg::CFG_TIME_STEP, 32'(dt));
        write_reg(bmi_pkg::CFG_AREA_WIDTH, 32'(aw));
        write_reg(bmi_pkg::CFG_AREA_HEIGHT, 32'(ah));
    endtask

    task automatic send_body(input body_t b);
        while ($urandom_range(99) < sender_idle)
        begin
            in_item.valid <= 1'b0;
            @(posedge clk);
        end
        in_item.valid <= 1'b1;
        in_item.pos_x <= b.pos_x;
        in_item.pos_y <= b.pos_y;
        in_item.vel_x <= b.vel_x;
        in_item.vel_y <= b.vel_y;
        in_item.body_mass <= b.body_mass;
        in_item.force_x <= b.force_x;
        in_item.force_y <= b.force_y;
        in_item.drag_fraction <= b.drag_fraction;
        in_item.box_width <= b.box_width;
        in_item.box_height <= b.box_height;
        @(posedge clk);
        while (!in_item.ready)
        begin
            @(posedge clk);
        end
        bodies_sent++;
    endtask

    task automatic finish_sending();
        in_item.valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (results_sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (80) @(posedge clk);
    endtask

    function automatic logic [31:0] any_word();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    function automatic body_t random_body(input bit in_range);
        body_t b;
        if (in_range)
        begin
            b.pos_x = $signed($urandom_range(cur_area_width + 20)) * 65536 - 32'sd655360
                      + $urandom_range(65535);
            b.pos_y = $signed($urandom_range(cur_area_height + 20)) * 65536 - 32'sd655360
                      + $urandom_range(65535);
            b.vel_x = $signed($urandom_range(400 * 65536)) - 200 * 65536;
            b.vel_y = $signed($urandom_range(400 * 65536)) - 200 * 65536;
            b.body_mass = ($urandom_range(9) == 0) ? 31'd0 : 31'($urandom_range(20 * 65536));
            b.force_x = ($urandom_range(3) == 0) ? 0 :
                        $signed($urandom_range(2000 * 65536)) - 1000 * 65536;
            b.force_y = ($urandom_range(3) == 0) ? 0 :
                        $signed($urandom_range(2000 * 65536)) - 1000 * 65536;
            b.drag_fraction = ($urandom_range(3) == 0) ? 17'd0 : 17'($urandom_range(8000));
            b.box_width = 12'($urandom_range(64));
            b.box_height = 12'($urandom_range(64));
        end
        else
        begin
            b.pos_x = any_word();
            b.pos_y = any_word();
            b.vel_x = any_word();
            b.vel_y = any_word();
            b.body_mass = ($urandom_range(4) == 0) ? 31'd0 : 31'(any_word());
            b.force_x = ($urandom_range(3) == 0) ? 0 : any_word();
            b.force_y = ($urandom_range(3) == 0) ? 0 : any_word();
            b.drag_fraction = 17'($urandom());
            b.box_width = 12'($urandom());
            b.box_height = 12'($urandom());
        end
        return b;
    endfunction

    function automatic body_t plain_body(input longint px, input longint py, input longint vx,
                                         input longint vy, input longint m, input longint fx,
                                         input longint fy, input int drag, input int bw,
                                         input int bh);
        body_t b;
        b.pos_x = 32'(px);
        b.pos_y = 32'(py);
        b.vel_x = 32'(vx);
        b.vel_y = 32'(vy);
        b.body_mass = 31'(m);
        b.force_x = 32'(fx);
        b.force_y = 32'(fy);
        b.drag_fraction = 17'(drag);
        b.box_width = 12'(bw);
        b.box_height = 12'(bh);
        return b;
    endfunction

    task automatic send_directed();
        send_body(plain_body(100 <<< 16, 100 <<< 16, 3 <<< 16, -2 <<< 16, 1 <<< 16,
                             0, 0, 0, 10, 10));
        send_body(plain_body(100 <<< 16, 100 <<< 16, 0, 0, 0, 5 <<< 16, 0, 0, 10, 10));
        send_body(plain_body(100 <<< 16, 100 <<< 16, 0, 0, 0, 0, -7, 0, 10, 10));
        send_body(plain_body(100 <<< 16, 100 <<< 16, 5, 5, 0, 0, 0, 0, 10, 10));
        send_body(plain_body(0, 0, 0, 0, 1, 32'sh7fffffff, -32'sh80000000, 0, 1, 1));
        send_body(plain_body(10 <<< 16, 10 <<< 16, 50 <<< 16, 50 <<< 16, 1 <<< 16,
                             0, 0, 17'h1ffff, 1, 1));
        send_body(plain_body(10 <<< 16, 10 <<< 16, 50 <<< 16, 50 <<< 16, 1 <<< 16,
                             0, 0, 65536, 1, 1));
        send_body(plain_body(-5 <<< 16, -5 <<< 16, -9 <<< 16, -9 <<< 16, 2 <<< 16,
                             0, 0, 100, 4, 4));
        send_body(plain_body(700 <<< 16, 500 <<< 16, 9 <<< 16, 9 <<< 16, 2 <<< 16,
                             0, 0, 100, 4, 4));
        send_body(plain_body(100 <<< 16, 100 <<< 16, 1, 1, 1 <<< 16, 0, 0, 0, 4095, 4095));
        send_body(plain_body(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                             31'h7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0));
        send_body(plain_body(-32'sh80000000, -32'sh80000000, -32'sh80000000,
                             -32'sh80000000, 1, -32'sh80000000, -32'sh80000000, 0, 0, 0));
        send_body(plain_body(320 <<< 16, 479 <<< 16, 4 <<< 16, 30 <<< 16, 1 <<< 16,
                             0, 0, 0, 8, 8));
        send_body(plain_body(0, 0, 0, 0, 31'h7fffffff, 0, 0, 17'h10000, 12'hfff, 0));
    endtask

    task automatic run_phase(input int count, input int idle_in, input int idle_out);
        sender_idle = idle_in;
        receiver_idle = idle_out;
        for (int i = 0; i < count; i++)
        begin
            send_body(random_body($urandom_range(3) != 0));
        end
        finish_sending();
        drain_results();
    endtask

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        cur_gravity = 0;
        cur_gravity_on = 1'b1;
        cur_time_step = 17'd1092;
        cur_area_width = 12'd640;
        cur_area_height = 12'd480;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        finish_sending();
        drain_results();

        set_config(32'sd9 <<< 16, 1'b1, 17'd1092, 12'd640, 12'd480);
        send_directed();
        finish_sending();
        drain_results();

        run_phase(150, 8, 69);

        set_config(32'h7fffffff, 1'b1, 17'h1ffff, 12'd4095, 12'd4095);
        run_phase(100, 69, 8);

        set_config(32'h80000000, 1'b0, 17'd0, 12'd1, 12'd1);
        run_phase(50, 0, 0);

        set_config(-32'sd20 <<< 16, 1'b1, 17'd65536, 12'd200, 12'd150);
        run_phase(100, 0, 0);

        set_config(32'sd3 <<< 16, 1'b1, 17'd2184, 12'd0, 12'd0);
        run_phase(50, 8, 69);

        set_config(32'sd9 <<< 16, 1'b1, 17'd1092, 12'd320, 12'd240);
        sender_idle = 0;
        receiver_idle = 0;
        hold_cycles = 300;
        for (int i = 0; i < 150; i++)
        begin
            send_body(random_body(1'b1));
        end
        finish_sending();
        drain_results();

        $display("Sent %0d bodies over seven register settings; %0d mass faults seen.",
                 bodies_sent, faults_seen);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
